/* hw/rtl/bgra_nv12_pkg.sv */
// Shared types, fixed-point coefficients and rounding for the BGRA to NV12 converter.
`timescale 1ns / 1ps

package bgra_nv12_pkg;

   localparam int FW_W = 13;           // frame width register
   localparam int EW_W = FW_W + 1;     // effective width, holds up to 8192
   localparam int FW_RESET = 1920;

   localparam int SUM2_W = 9;          // sum of two channel values
   localparam int SUM4_W = 10;         // sum of four channel values
   localparam int LINE_W = 3 * SUM2_W;

   localparam int KY_W = 24;           // luma coefficient, unsigned Q.24
   localparam int KC_W = 21;           // chroma coefficient magnitude, Q.24
   localparam int LPROD_W = KY_W + 8;
   localparam int CPROD_W = KC_W + SUM4_W;
   localparam int ACC_W = 36;
   localparam int FRAC_W = 24;

   localparam longint unsigned Q_ONE = 64'd1 << FRAC_W;
   localparam longint unsigned Y_DEN = 64'd2550000;
   localparam longint unsigned C_DEN = 64'd1020000000;

   localparam logic [KY_W-1:0] KY_R = KY_W'((64'd219 * 64'd2126 * Q_ONE + Y_DEN / 2) / Y_DEN);
   localparam logic [KY_W-1:0] KY_G = KY_W'((64'd219 * 64'd7152 * Q_ONE + Y_DEN / 2) / Y_DEN);
   localparam logic [KY_W-1:0] KY_B = KY_W'((64'd219 * 64'd722 * Q_ONE + Y_DEN / 2) / Y_DEN);

   // Magnitudes; signs are applied when the products are combined.
   localparam logic [KC_W-1:0] KC_HALF =
      KC_W'((64'd224 * 64'd500000 * Q_ONE + C_DEN / 2) / C_DEN);
   localparam logic [KC_W-1:0] KCB_R =
      KC_W'((64'd224 * 64'd114572 * Q_ONE + C_DEN / 2) / C_DEN);
   localparam logic [KC_W-1:0] KCB_G =
      KC_W'((64'd224 * 64'd385428 * Q_ONE + C_DEN / 2) / C_DEN);
   localparam logic [KC_W-1:0] KCR_G =
      KC_W'((64'd224 * 64'd454153 * Q_ONE + C_DEN / 2) / C_DEN);
   localparam logic [KC_W-1:0] KCR_B =
      KC_W'((64'd224 * 64'd45847 * Q_ONE + C_DEN / 2) / C_DEN);

   localparam logic [ACC_W-1:0] Y_OFFSET = ACC_W'(64'd16 << FRAC_W);
   localparam logic [ACC_W-1:0] C_OFFSET = ACC_W'(64'd128 << FRAC_W);
   localparam logic [ACC_W-1:0] Q_HALF = ACC_W'(64'd1 << (FRAC_W - 1));

   localparam logic [7:0] Y_LO = 8'd16;
   localparam logic [7:0] Y_HI = 8'd235;
   localparam logic [7:0] C_LO = 8'd16;
   localparam logic [7:0] C_HI = 8'd240;
   localparam logic [7:0] C_NEUTRAL = 8'd128;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } rsp_type;

   // Front end to arithmetic: pixel plus 2x2 channel totals.
   typedef struct packed {
      logic              valid;
      logic              chroma;
      logic [7:0]        blue;
      logic [7:0]        green;
      logic [7:0]        red;
      logic [SUM4_W-1:0] sum_b;
      logic [SUM4_W-1:0] sum_g;
      logic [SUM4_W-1:0] sum_r;
   } pix_sum_type;

   // Round half away from zero (value is never negative past the clamp) and clamp.
   function automatic logic [7:0] round_clamp(input logic signed [ACC_W-1:0] total,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
      logic [ACC_W-1:0]        biased;
      logic [ACC_W-FRAC_W-1:0] q;
      logic [7:0]              res;
      biased = $unsigned(total) + Q_HALF;
      q = biased[ACC_W-1:FRAC_W];
      if (total[ACC_W-1]) begin
         res = lo;
      end else if (q < (ACC_W-FRAC_W)'(lo)) begin
         res = lo;
      end else if (q > (ACC_W-FRAC_W)'(hi)) begin
         res = hi;
      end else begin
         res = q[7:0];
      end
      return res;
   endfunction

endpackage

/* hw/rtl/bgra_to_nv12_bt709.sv */
// BGRA to NV12 (BT.709 limited range) top level: width register, flow control, assertions.
// Takes one BGRA pixel per clock in raster order while the output is not stalled, and returns
// one result per pixel through the stage 1, product and output registers: luma for every
// pixel and, on the bottom-right pixel of each 2x2 block, Cb and Cr of the block average. The
// three pipeline stages advance together whenever the output register is empty or being
// drained, so a full-rate stream runs at one pixel per cycle with no bubbles. Top-row pair sums
// are kept in a MAX_WIDTH/2 x 27-bit line memory read at the edge that loads stage 1; it has no
// reset and no clearing pass, so a bottom-row read of an entry never written in a top row
// returns whatever it last held. csr_wr_data sets the row length (low bit ignored; zero or above
// MAX_WIDTH means MAX_WIDTH) and should only be written while no request is in flight.
`timescale 1ns / 1ps

module bgra_to_nv12_bt709 import bgra_nv12_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_type         rsp_data,
   input  logic            csr_wr_en,
   input  logic [FW_W-1:0] csr_wr_data
);

   localparam logic [EW_W-1:0] EFF_RESET =
      (FW_RESET > MAX_WIDTH) ? EW_W'(MAX_WIDTH) : EW_W'(FW_RESET);

   logic [EW_W-1:0] eff_width_ff, eff_width_in;
   logic [FW_W-1:0] fw_even;
   logic            advance, accept;
   pix_sum_type     pix;

   always_comb begin
      fw_even = {csr_wr_data[FW_W-1:1], 1'b0};
      eff_width_in = eff_width_ff;
      if (csr_wr_en) begin
         if (fw_even == '0 || EW_W'(fw_even) > EW_W'(MAX_WIDTH)) begin
            eff_width_in = EW_W'(MAX_WIDTH);
         end else begin
            eff_width_in = EW_W'(fw_even);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff <= EFF_RESET;
      end else begin
         eff_width_ff <= eff_width_in;
      end
   end

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   bgra_nv12_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (advance),
      .req_data  (req_data),
      .eff_width (eff_width_ff),
      .pix       (pix)
   );

   bgra_nv12_math u_math (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pix       (pix),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.luma >= Y_LO && rsp_data.luma <= Y_HI))
      else $error("luma out of range");

   a_chroma_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.chroma_valid) |->
         (rsp_data.chroma_blue >= C_LO && rsp_data.chroma_blue <= C_HI &&
          rsp_data.chroma_red >= C_LO && rsp_data.chroma_red <= C_HI))
      else $error("chroma out of range");

   a_chroma_neutral: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.chroma_valid) |->
         (rsp_data.chroma_blue == C_NEUTRAL && rsp_data.chroma_red == C_NEUTRAL))
      else $error("chroma not neutral outside 2x2 corner");

   a_width_even: assert property (@(posedge clock) disable iff (reset)
      (eff_width_ff != '0) && (eff_width_ff <= EW_W'(MAX_WIDTH)) && !eff_width_ff[0])
      else $error("effective width invalid");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");
`endif

endmodule

/* hw/rtl/bgra_nv12_front.sv */
// Raster position tracking, left-pixel hold and pair-sum line memory.
`timescale 1ns / 1ps

module bgra_nv12_front import bgra_nv12_pkg::*; #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              advance,
   input  req_type           req_data,
   input  logic [EW_W-1:0]   eff_width,
   output pix_sum_type       pix
);

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

   logic [COL_W-1:0]  column_count_ff, column_count_in;
   logic              row_odd_ff, row_odd_in;
   logic [23:0]       left_pixel_ff, left_pixel_in;

   logic [LINE_W-1:0] line_mem [LINE_DEPTH];
   logic [LINE_W-1:0] line_rd_ff;

   // stage 1 registers
   logic              s1_valid_ff;
   logic              s1_chroma_ff;
   logic [7:0]        s1_blue_ff, s1_green_ff, s1_red_ff;
   logic [SUM2_W-1:0] s1_pb_ff, s1_pg_ff, s1_pr_ff;

   logic [COL_W-1:0]  col_start, col;
   logic              row_cur, col_odd, last_col;
   logic [IDX_W-1:0]  idx;
   logic [SUM2_W-1:0] pb, pg, pr;
   logic              line_we, line_re;

   always_comb begin
      col_start = req_data.frame_start ? '0 : column_count_ff;
      row_cur   = req_data.frame_start ? 1'b0 : row_odd_ff;
      // width shrunk mid-row: restart at column 0
      col       = (EW_W'(col_start) >= eff_width) ? '0 : col_start;
      col_odd   = col[0];
      last_col  = (EW_W'(col) + EW_W'(1)) >= eff_width;
      idx       = IDX_W'(col >> 1);

      pb = SUM2_W'(req_data.blue)  + SUM2_W'(left_pixel_ff[7:0]);
      pg = SUM2_W'(req_data.green) + SUM2_W'(left_pixel_ff[15:8]);
      pr = SUM2_W'(req_data.red)   + SUM2_W'(left_pixel_ff[23:16]);

      line_we = accept && col_odd && !row_cur;
      line_re = accept && col_odd && row_cur;

      column_count_in = column_count_ff;
      row_odd_in      = row_odd_ff;
      left_pixel_in   = left_pixel_ff;
      if (accept) begin
         column_count_in = last_col ? '0 : col + COL_W'(1);
         row_odd_in      = last_col ? !row_cur : row_cur;
         if (!col_odd) begin
            left_pixel_in = {req_data.red, req_data.green, req_data.blue};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_odd_ff      <= 1'b0;
         left_pixel_ff   <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_odd_ff      <= row_odd_in;
         left_pixel_ff   <= left_pixel_in;
      end
   end

   // Top-row writes and bottom-row reads are never enabled together; a read of an entry
   // with no earlier top-row write returns whatever the entry last held.
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[idx] <= {pr, pg, pb};
      end
      if (line_re) begin
         line_rd_ff <= line_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_chroma_ff <= col_odd && row_cur;
         s1_blue_ff   <= req_data.blue;
         s1_green_ff  <= req_data.green;
         s1_red_ff    <= req_data.red;
         s1_pb_ff     <= pb;
         s1_pg_ff     <= pg;
         s1_pr_ff     <= pr;
      end
   end

   always_comb begin
      pix.valid  = s1_valid_ff;
      pix.chroma = s1_chroma_ff;
      pix.blue   = s1_blue_ff;
      pix.green  = s1_green_ff;
      pix.red    = s1_red_ff;
      pix.sum_b  = SUM4_W'(s1_pb_ff) + SUM4_W'(line_rd_ff[SUM2_W-1:0]);
      pix.sum_g  = SUM4_W'(s1_pg_ff) + SUM4_W'(line_rd_ff[2*SUM2_W-1:SUM2_W]);
      pix.sum_r  = SUM4_W'(s1_pr_ff) + SUM4_W'(line_rd_ff[3*SUM2_W-1:2*SUM2_W]);
   end

endmodule

/* hw/rtl/bgra_nv12_math.sv */
// Colour matrix products, offset, rounding and clamping, with the output register.
`timescale 1ns / 1ps

module bgra_nv12_math import bgra_nv12_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  pix_sum_type pix,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   logic               s2_valid_ff;
   logic               s2_chroma_ff;
   logic [LPROD_W-1:0] y_r_ff, y_g_ff, y_b_ff;
   logic [CPROD_W-1:0] cb_b_ff, cb_r_ff, cb_g_ff;
   logic [CPROD_W-1:0] cr_r_ff, cr_g_ff, cr_b_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic signed [ACC_W-1:0] y_total, cb_total, cr_total;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_chroma_ff <= pix.chroma;
         y_r_ff  <= LPROD_W'(KY_R) * LPROD_W'(pix.red);
         y_g_ff  <= LPROD_W'(KY_G) * LPROD_W'(pix.green);
         y_b_ff  <= LPROD_W'(KY_B) * LPROD_W'(pix.blue);
         cb_b_ff <= CPROD_W'(KC_HALF) * CPROD_W'(pix.sum_b);
         cb_r_ff <= CPROD_W'(KCB_R) * CPROD_W'(pix.sum_r);
         cb_g_ff <= CPROD_W'(KCB_G) * CPROD_W'(pix.sum_g);
         cr_r_ff <= CPROD_W'(KC_HALF) * CPROD_W'(pix.sum_r);
         cr_g_ff <= CPROD_W'(KCR_G) * CPROD_W'(pix.sum_g);
         cr_b_ff <= CPROD_W'(KCR_B) * CPROD_W'(pix.sum_b);
      end
   end

   always_comb begin
      y_total  = $signed(Y_OFFSET + ACC_W'(y_r_ff) + ACC_W'(y_g_ff) + ACC_W'(y_b_ff));
      cb_total = $signed(C_OFFSET + ACC_W'(cb_b_ff) - ACC_W'(cb_r_ff) - ACC_W'(cb_g_ff));
      cr_total = $signed(C_OFFSET + ACC_W'(cr_r_ff) - ACC_W'(cr_g_ff) - ACC_W'(cr_b_ff));

      rsp_in.luma         = round_clamp(y_total, Y_LO, Y_HI);
      rsp_in.chroma_valid = s2_chroma_ff;
      rsp_in.chroma_blue  = s2_chroma_ff ? round_clamp(cb_total, C_LO, C_HI) : C_NEUTRAL;
      rsp_in.chroma_red   = s2_chroma_ff ? round_clamp(cr_total, C_LO, C_HI) : C_NEUTRAL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= pix.valid;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* dv/bgra_to_nv12_bt709_test.sv */
// Self-checking testbench for the BGRA to NV12 converter: directed table, then random pixel streams.
`timescale 1ns / 1ps

module bgra_to_nv12_bt709_test;
   import bgra_nv12_pkg::*;

   localparam int PIXELS_MAX  = 4096;
   localparam int LINE_SLOTS  = PIXELS_MAX / 2;
   localparam int RANDOM_GOAL = 700;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 4;
   localparam int PRINT_CAP   = 100;

   // Q.24 coefficients, chroma ones as magnitudes
   localparam longint ONE_Q  = 64'sd16777216;
   localparam longint HALF_Q = 64'sd8388608;
   localparam longint Y_R  = (219 * 2126 * ONE_Q + 1275000) / 2550000;
   localparam longint Y_G  = (219 * 7152 * ONE_Q + 1275000) / 2550000;
   localparam longint Y_B  = (219 * 722 * ONE_Q + 1275000) / 2550000;
   localparam longint C_HALF = (224 * 500000 * ONE_Q + 510000000) / 1020000000;
   localparam longint CB_R = (224 * 114572 * ONE_Q + 510000000) / 1020000000;
   localparam longint CB_G = (224 * 385428 * ONE_Q + 510000000) / 1020000000;
   localparam longint CR_G = (224 * 454153 * ONE_Q + 510000000) / 1020000000;
   localparam longint CR_B = (224 * 45847 * ONE_Q + 510000000) / 1020000000;

   typedef struct packed {
      bit         set_width;
      logic [FW_W-1:0] width;
      req_type    px;
      bit         typed;
      rsp_type    want;
   } stim_row_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_type         req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_type         rsp_data;
   logic            csr_wr_en;
   logic [FW_W-1:0] csr_wr_data;

   // converter state as the predictor sees it
   logic [FW_W-1:0] width_reg = FW_W'(FW_RESET);
   int              col_count = 0;
   bit              row_is_odd = 1'b0;
   int              left_b = 0, left_g = 0, left_r = 0;
   int              top_b [LINE_SLOTS];
   int              top_g [LINE_SLOTS];
   int              top_r [LINE_SLOTS];
   bit              top_written [LINE_SLOTS];

   rsp_type         results_due [$];
   int              errors = 0;
   int              quiet_cycles = 0;
   bit              quiet_stretch = 1'b0;

   bgra_to_nv12_bt709 u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int effective_width();
      int w;
      w = int'(width_reg) & 32'h1FFE;
      if (w == 0 || w > PIXELS_MAX) begin
         w = PIXELS_MAX;
      end
      return w;
   endfunction

   function automatic logic [7:0] round_and_limit(input longint acc, input longint offset,
                                                  input int lo, input int hi);
      longint total;
      longint q;
      total = offset * ONE_Q + acc;
      if (total < 0) begin
         return lo[7:0];
      end
      q = (total + HALF_Q) >>> 24;
      if (q < lo) begin
         q = longint'(lo);
      end
      if (q > hi) begin
         q = longint'(hi);
      end
      return q[7:0];
   endfunction

   // true when this pixel would be the bottom half of a pair whose top half was never stored
   function automatic bit hits_blank_entry(input req_type px);
      int col;
      col = (col_count >= effective_width()) ? 0 : col_count;
      return !px.frame_start && row_is_odd && col[0] && !top_written[col >> 1];
   endfunction

   task automatic convert_pixel(input req_type px, output rsp_type res);
      int     w, col, idx, sb, sg, sr, tb, tg, tr;
      longint acc;
      w = effective_width();
      if (px.frame_start) begin
         col_count = 0;
         row_is_odd = 1'b0;
      end
      if (col_count >= w) begin
         col_count = 0;
      end
      col = col_count;
      acc = Y_R * int'(px.red) + Y_G * int'(px.green) + Y_B * int'(px.blue);
      res.luma = round_and_limit(acc, 16, 16, 235);
      res.chroma_valid = 1'b0;
      res.chroma_blue = 8'd128;
      res.chroma_red = 8'd128;
      if (!col[0]) begin
         left_b = int'(px.blue);
         left_g = int'(px.green);
         left_r = int'(px.red);
      end else begin
         idx = col >> 1;
         sb = int'(px.blue) + left_b;
         sg = int'(px.green) + left_g;
         sr = int'(px.red) + left_r;
         if (!row_is_odd) begin
            top_b[idx] = sb;
            top_g[idx] = sg;
            top_r[idx] = sr;
            top_written[idx] = 1'b1;
         end else begin
            tb = sb + top_b[idx];
            tg = sg + top_g[idx];
            tr = sr + top_r[idx];
            acc = C_HALF * tb - CB_R * tr - CB_G * tg;
            res.chroma_blue = round_and_limit(acc, 128, 16, 240);
            acc = C_HALF * tr - CR_G * tg - CR_B * tb;
            res.chroma_red = round_and_limit(acc, 128, 16, 240);
            res.chroma_valid = 1'b1;
         end
      end
      if (col + 1 >= w) begin
         col_count = 0;
         row_is_odd = !row_is_odd;
      end else begin
         col_count = col + 1;
      end
   endtask

   task automatic flag_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= PRINT_CAP) begin
         $display("%0t ns  %s: got %0d, want %0d", $time, what, got, want);
      end
   endtask

   function automatic stim_row_type plan_step(input bit set_w, input int width, input int b,
                                              input int g, input int r, input bit fs,
                                              input bit typed, input int y, input bit cv,
                                              input int cb, input int cr);
      stim_row_type row;
      row.set_width = set_w;
      row.width = FW_W'(width);
      row.px.blue = 8'(b);
      row.px.green = 8'(g);
      row.px.red = 8'(r);
      row.px.frame_start = fs;
      row.typed = typed;
      row.want.luma = 8'(y);
      row.want.chroma_valid = cv;
      row.want.chroma_blue = 8'(cb);
      row.want.chroma_red = 8'(cr);
      return row;
   endfunction

   function automatic logic [7:0] random_channel();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return 8'd0;
      end else if (pick == 1) begin
         return 8'd255;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_pixel(input req_type px, input bit typed, input rsp_type want);
      rsp_type res;
      if (hits_blank_entry(px)) begin
         px.frame_start = 1'b1;
      end
      @(negedge clock);
      while (!quiet_stretch && $urandom_range(0, 99) < 14) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= px;
      do begin
         @(posedge clock);
      end while (!req_ready);
      convert_pixel(px, res);
      results_due.push_back(typed ? want : res);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_width(input logic [FW_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      width_reg = value;
   endtask

   always @(negedge clock) begin
      rsp_ready <= quiet_stretch || ($urandom_range(0, 99) >= 14);
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (results_due.size() == 0) begin
            flag_mismatch("result with none due, luma", int'(rsp_data.luma), 0);
         end else begin
            want = results_due.pop_front();
            if (rsp_data.luma !== want.luma)
               flag_mismatch("luma", int'(rsp_data.luma), int'(want.luma));
            if (rsp_data.chroma_valid !== want.chroma_valid)
               flag_mismatch("chroma_valid", int'(rsp_data.chroma_valid),
                             int'(want.chroma_valid));
            if (rsp_data.chroma_blue !== want.chroma_blue)
               flag_mismatch("chroma_blue", int'(rsp_data.chroma_blue),
                             int'(want.chroma_blue));
            if (rsp_data.chroma_red !== want.chroma_red)
               flag_mismatch("chroma_red", int'(rsp_data.chroma_red), int'(want.chroma_red));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("bgra_to_nv12_bt709: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type plan [$];
      req_type px;
      int      sent, n, ew, w;
      bit      restart;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;

      // reset width: black then white on row 0
      plan.push_back(plan_step(0, 0, 0, 0, 0, 1, 1, 16, 0, 128, 128));
      plan.push_back(plan_step(0, 0, 255, 255, 255, 0, 1, 235, 0, 128, 128));
      // narrowest rows: a black 2x2 block gives neutral chroma
      plan.push_back(plan_step(1, 2, 0, 0, 0, 1, 1, 16, 0, 128, 128));
      plan.push_back(plan_step(0, 0, 0, 0, 0, 0, 1, 16, 0, 128, 128));
      plan.push_back(plan_step(0, 0, 0, 0, 0, 0, 1, 16, 0, 128, 128));
      plan.push_back(plan_step(0, 0, 0, 0, 0, 0, 1, 16, 1, 128, 128));
      // saturated primaries, mixed into one 2x2 block
      plan.push_back(plan_step(0, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 0, 255, 0, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 0, 0, 255, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 255, 0, 0, 0, 0, 0, 0, 0, 0));
      // zero, oversize and just-over-limit widths fall back to the maximum
      plan.push_back(plan_step(1, 0, 17, 99, 201, 1, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(1, 8191, 200, 1, 3, 1, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(1, 4097, 255, 255, 0, 1, 0, 0, 0, 0, 0));
      // width shrinks under the column count: next pixel restarts the row
      plan.push_back(plan_step(1, 6, 10, 20, 30, 1, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 40, 50, 60, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 70, 80, 90, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 100, 110, 120, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(1, 3, 130, 140, 150, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 160, 170, 180, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 190, 200, 210, 0, 0, 0, 0, 0, 0));
      plan.push_back(plan_step(0, 0, 220, 230, 240, 0, 0, 0, 0, 0, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].set_width) begin
            drain_results();
            write_width(plan[i].width);
         end
         send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end

      sent = 0;
      while (sent < RANDOM_GOAL) begin
         case ($urandom_range(0, 11))
            0: w = 2;
            1: w = 3;
            2: w = 0;
            3: w = 8191;
            4: w = 4096;
            5: w = 4097;
            6: w = $urandom_range(41, 130);
            default: w = $urandom_range(2, 40);
         endcase
         drain_results();
         write_width(FW_W'(w));
         ew = effective_width();
         if (ew > 130) begin
            n = $urandom_range(8, 40);
         end else if (ew > 64) begin
            n = 2 * ew;
         end else begin
            n = ew * $urandom_range(2, 6);
         end
         // most phases start a fresh frame; the rest carry the old position over
         restart = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < n && sent < RANDOM_GOAL; i++) begin
            quiet_stretch = (sent >= 250 && sent < 420);
            px.blue = random_channel();
            px.green = random_channel();
            px.red = random_channel();
            px.frame_start = (i == 0 && restart) || ($urandom_range(0, 99) < 3);
            send_pixel(px, 1'b0, '0);
            sent++;
         end
      end
      quiet_stretch = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("bgra_to_nv12_bt709: match");
      end else begin
         $display("bgra_to_nv12_bt709: mismatch");
      end
      $finish;
   end

endmodule
